// ===== src/esdt_pkg.sv =====
package esdt_pkg;

  // Fixed widths of the datapath
  localparam int unsigned SecsW    = 32;
  localparam int unsigned DivisorW = 17;
  localparam int unsigned RemW     = 17;
  localparam int unsigned QuoW     = 16;
  localparam int unsigned DaysW    = 16;
  localparam int unsigned YearW    = 12;

  // Time constants
  localparam logic [DivisorW-1:0] SECS_PER_DAY  = 17'd86400;
  localparam logic [DivisorW-1:0] SECS_PER_HOUR = 17'd3600;
  localparam logic [DivisorW-1:0] SECS_PER_MIN  = 17'd60;

  // Reciprocals floor(2^32 / divisor); the estimate is at most one short
  localparam logic [SecsW-1:0] RCP_PER_DAY  = 32'd49710;
  localparam logic [SecsW-1:0] RCP_PER_HOUR = 32'd1193046;
  localparam logic [SecsW-1:0] RCP_PER_MIN  = 32'd71582788;

  // Calendar constants
  localparam logic [YearW-1:0] FIRST_YEAR     = 12'd1970;
  localparam logic [6:0]       FIRST_YEAR_M100 = 7'd70;
  localparam logic [8:0]       FIRST_YEAR_M400 = 9'd370;
  localparam logic [6:0]       CENTURY         = 7'd100;
  localparam logic [8:0]       QUAD_CENTURY    = 9'd400;
  localparam logic [8:0]       YEAR_LEN        = 9'd365;
  localparam logic [8:0]       LEAP_YEAR_LEN   = 9'd366;
  localparam logic [3:0]       JANUARY         = 4'd1;
  localparam logic [3:0]       FEBRUARY        = 4'd2;
  localparam logic [3:0]       DECEMBER        = 4'd12;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DAY,
    S_HOUR,
    S_MIN,
    S_YEAR,
    S_MONTH,
    S_DONE
  } state_t;

  // Divider phases
  typedef enum logic [1:0] {
    D_IDLE,
    D_EST,
    D_REM,
    D_FIX
  } div_phase_t;

  // Request to the shared divider
  typedef struct packed {
    logic                start;
    logic [SecsW-1:0]    dividend;
    logic [DivisorW-1:0] divisor;
    logic [SecsW-1:0]    recip;
  } div_req_t;

  // Response from the shared divider
  typedef struct packed {
    logic            done;
    logic [QuoW-1:0] quo;
    logic [RemW-1:0] rem;
  } div_rsp_t;

  // Days in month m, February follows the leap flag
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    len = 5'd31;
    if (m == FEBRUARY) begin
      len = leap ? 5'd29 : 5'd28;
    end else if (m inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
      len = 5'd30;
    end
    return len;
  endfunction

endpackage

// ===== src/epoch_seconds_to_datetime_core.sv =====
// One request in flight at a time.
// Three passes of the shared divide-by-constant unit (reciprocal multiply, multiply back,
// fix up) split seconds into days, hours, minutes and seconds; then one year per cycle
// and one month per cycle are peeled off the day count.
// A new request is taken while a result waits in the output register.
// Reset: rst_n synchronous, active low; clears the sequencer and result valid.
module epoch_seconds_to_datetime_core
  import esdt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_epoch_seconds,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] out_year_out,
  output logic [3:0]  out_month_out,
  output logic [4:0]  out_day_out,
  output logic [4:0]  out_hour_out,
  output logic [5:0]  out_minute_out,
  output logic [5:0]  out_second_out
);

  state_t          state_r, state_nxt;
  logic [DaysW-1:0] days_r,  days_nxt;
  logic [YearW-1:0] year_r,  year_nxt;
  logic [6:0]       m100_r,  m100_nxt;
  logic [8:0]       m400_r,  m400_nxt;
  logic [3:0]       month_r, month_nxt;
  logic [4:0]       hour_r,  hour_nxt;
  logic [5:0]       min_r,   min_nxt;
  logic [5:0]       sec_r,   sec_nxt;
  logic             ovld_r,  ovld_nxt;
  logic [11:0]      oyear_r;
  logic [3:0]       omonth_r;
  logic [4:0]       oday_r;
  logic [4:0]       ohour_r;
  logic [5:0]       omin_r;
  logic [5:0]       osec_r;

  div_req_t   div_req;
  div_rsp_t   div_rsp;
  logic       in_acc;
  logic       out_free;
  logic       leap;
  logic [8:0] ylen;
  logic [4:0] mlen;
  logic       year_more;
  logic       month_more;

  esdt_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !ovld_r || !out_stall;

  // Leap flag of the current year from running residues
  assign leap       = (m400_r == '0) || ((year_r[1:0] == 2'b00) && (m100_r != '0));
  assign ylen       = leap ? LEAP_YEAR_LEN : YEAR_LEN;
  assign mlen       = month_len(month_r, leap);
  assign year_more  = (days_r > {7'b0, ylen});
  assign month_more = (days_r > {11'b0, mlen}) && (month_r != DECEMBER);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_acc) state_nxt = S_DAY;
      S_DAY:   if (div_rsp.done) state_nxt = S_HOUR;
      S_HOUR:  if (div_rsp.done) state_nxt = S_MIN;
      S_MIN:   if (div_rsp.done) state_nxt = S_YEAR;
      S_YEAR:  if (!year_more) state_nxt = S_MONTH;
      S_MONTH: if (!month_more) state_nxt = S_DONE;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Divider requests
  always_comb begin
    div_req = '0;
    case (state_r)
      S_IDLE: begin
        div_req.start    = in_acc;
        div_req.dividend = in_epoch_seconds;
        div_req.divisor  = SECS_PER_DAY;
        div_req.recip    = RCP_PER_DAY;
      end
      S_DAY: begin
        div_req.start    = div_rsp.done;
        div_req.dividend = {15'b0, div_rsp.rem};
        div_req.divisor  = SECS_PER_HOUR;
        div_req.recip    = RCP_PER_HOUR;
      end
      S_HOUR: begin
        div_req.start    = div_rsp.done;
        div_req.dividend = {20'b0, div_rsp.rem[11:0]};
        div_req.divisor  = SECS_PER_MIN;
        div_req.recip    = RCP_PER_MIN;
      end
      default: div_req = '0;
    endcase
  end

  // Datapath updates
  always_comb begin
    days_nxt  = days_r;
    year_nxt  = year_r;
    m100_nxt  = m100_r;
    m400_nxt  = m400_r;
    month_nxt = month_r;
    hour_nxt  = hour_r;
    min_nxt   = min_r;
    sec_nxt   = sec_r;
    ovld_nxt  = ovld_r && out_stall;
    case (state_r)
      S_DAY: begin
        // One-based day number
        if (div_rsp.done) days_nxt = div_rsp.quo + 1'b1;
      end
      S_HOUR: begin
        if (div_rsp.done) hour_nxt = div_rsp.quo[4:0];
      end
      S_MIN: begin
        if (div_rsp.done) begin
          min_nxt  = div_rsp.quo[5:0];
          sec_nxt  = div_rsp.rem[5:0];
          year_nxt = FIRST_YEAR;
          m100_nxt = FIRST_YEAR_M100;
          m400_nxt = FIRST_YEAR_M400;
        end
      end
      S_YEAR: begin
        // Drop one whole year per cycle
        if (year_more) begin
          days_nxt = days_r - {7'b0, ylen};
          year_nxt = year_r + 1'b1;
          m100_nxt = (m100_r == CENTURY - 1'b1) ? '0 : m100_r + 1'b1;
          m400_nxt = (m400_r == QUAD_CENTURY - 1'b1) ? '0 : m400_r + 1'b1;
        end else begin
          month_nxt = JANUARY;
        end
      end
      S_MONTH: begin
        // Drop one whole month per cycle
        if (month_more) begin
          days_nxt  = days_r - {11'b0, mlen};
          month_nxt = month_r + 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) ovld_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovld_r  <= ovld_nxt;
    end
    days_r  <= days_nxt;
    year_r  <= year_nxt;
    m100_r  <= m100_nxt;
    m400_r  <= m400_nxt;
    month_r <= month_nxt;
    hour_r  <= hour_nxt;
    min_r   <= min_nxt;
    sec_r   <= sec_nxt;
  end

  // Hold the result in the output register until taken
  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      oyear_r  <= year_r;
      omonth_r <= month_r;
      oday_r   <= days_r[4:0];
      ohour_r  <= hour_r;
      omin_r   <= min_r;
      osec_r   <= sec_r;
    end
  end

  assign out_valid      = ovld_r;
  assign out_year_out   = oyear_r;
  assign out_month_out  = omonth_r;
  assign out_day_out    = oday_r;
  assign out_hour_out   = ohour_r;
  assign out_minute_out = omin_r;
  assign out_second_out = osec_r;

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_DAY))
    else $error("accepted request did not start the day division");
  a_days_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_YEAR || state_r == S_MONTH) |-> (days_r != '0))
    else $error("day count fell to zero");
  a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MONTH) |-> (month_r >= JANUARY && month_r <= DECEMBER))
    else $error("month walk left the year");
  a_day_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |-> (days_r <= {11'b0, mlen}))
    else $error("day of month exceeds month length");
`endif

endmodule

// ===== src/esdt_div.sv =====
module esdt_div
  import esdt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  div_phase_t          phase_r, phase_nxt;
  logic                done_r,  done_nxt;
  logic [SecsW-1:0]    dvd_r,   dvd_nxt;
  logic [DivisorW-1:0] dvsr_r,  dvsr_nxt;
  logic [SecsW-1:0]    rcp_r,   rcp_nxt;
  logic [QuoW-1:0]     quo_r,   quo_nxt;
  logic [RemW:0]       rem_r,   rem_nxt;
  logic [SecsW-1:0]    mul_a;
  logic [SecsW-1:0]    mul_b;
  logic [2*SecsW-1:0]  prod;
  logic [SecsW-1:0]    diff;
  logic                over;

  // Share one 32x32 multiplier: reciprocal estimate first, then multiply back
  assign mul_a = (phase_r == D_EST) ? dvd_r : {{(SecsW-QuoW){1'b0}}, quo_r};
  assign mul_b = (phase_r == D_EST) ? rcp_r : {{(SecsW-DivisorW){1'b0}}, dvsr_r};
  assign prod  = {{SecsW{1'b0}}, mul_a} * {{SecsW{1'b0}}, mul_b};
  assign diff  = dvd_r - prod[SecsW-1:0];
  assign over  = (rem_r >= {1'b0, dvsr_r});

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      D_IDLE:  if (req.start) phase_nxt = D_EST;
      D_EST:   phase_nxt = D_REM;
      D_REM:   phase_nxt = D_FIX;
      D_FIX:   phase_nxt = D_IDLE;
      default: phase_nxt = D_IDLE;
    endcase
  end

  // Load on start, estimate, multiply back, then fix up by one step
  always_comb begin
    done_nxt = 1'b0;
    dvd_nxt  = dvd_r;
    dvsr_nxt = dvsr_r;
    rcp_nxt  = rcp_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    case (phase_r)
      D_IDLE: begin
        if (req.start) begin
          dvd_nxt  = req.dividend;
          dvsr_nxt = req.divisor;
          rcp_nxt  = req.recip;
        end
      end
      D_EST: begin
        // Floor estimate, never above the true quotient
        quo_nxt = prod[SecsW +: QuoW];
      end
      D_REM: begin
        rem_nxt = diff[RemW:0];
      end
      D_FIX: begin
        // Fold in the one step the estimate may miss
        if (over) begin
          quo_nxt = quo_r + 1'b1;
          rem_nxt = rem_r - {1'b0, dvsr_r};
        end
        done_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= D_IDLE;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      done_r  <= done_nxt;
    end
    dvd_r  <= dvd_nxt;
    dvsr_r <= dvsr_nxt;
    rcp_r  <= rcp_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
  assign rsp.rem  = rem_r[RemW-1:0];

`ifndef SYNTHESIS
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> (phase_r == D_IDLE))
    else $error("divider started while busy");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (phase_r == D_IDLE))
    else $error("divider done while still busy");
  a_est_close: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == D_FIX) |-> (rem_r < {dvsr_r, 1'b0}))
    else $error("quotient estimate more than one short");
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (rem_r < {1'b0, dvsr_r}))
    else $error("remainder not below divisor");
  a_done_after_fix: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == D_FIX) |=> done_r)
    else $error("divider missed its done pulse");
`endif

endmodule

// ===== sim/tb_epoch_seconds_to_datetime_core.sv =====
module tb_epoch_seconds_to_datetime_core
  import esdt_pkg::*;
();

  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned DrainCycles   = 250;
  localparam int unsigned LongHold      = 600;
  localparam int unsigned DaySecs       = 86400;
  localparam int unsigned HourSecs      = 3600;
  localparam int unsigned MinuteSecs    = 60;
  localparam int unsigned LastDay       = 49710;

  // Days per month, index 0 unused; February is patched for leap years
  localparam int unsigned MonthDays [13] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } datetime_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_epoch_seconds = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [11:0] out_year_out;
  logic [3:0]  out_month_out;
  logic [4:0]  out_day_out;
  logic [4:0]  out_hour_out;
  logic [5:0]  out_minute_out;
  logic [5:0]  out_second_out;

  datetime_t   pending_datetimes[$];
  int unsigned error_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned long_hold_req = 0;

  epoch_seconds_to_datetime_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_epoch_seconds (in_epoch_seconds),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_year_out     (out_year_out),
    .out_month_out    (out_month_out),
    .out_day_out      (out_day_out),
    .out_hour_out     (out_hour_out),
    .out_minute_out   (out_minute_out),
    .out_second_out   (out_second_out)
  );

  initial begin : clock_gen
    forever #4 clk = ~clk;
  end

  function automatic bit is_leap_year(input int unsigned y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  function automatic int unsigned days_in_month(input int unsigned m, input bit leap);
    return (m == FEBRUARY && leap) ? 29 : MonthDays[m];
  endfunction

  // Split seconds into time of day, then peel off whole years and months
  function automatic datetime_t predict_datetime(input logic [31:0] secs);
    datetime_t   dt;
    int unsigned day_num;
    int unsigned rem;
    int unsigned yr;
    int unsigned ylen;
    int unsigned mon;
    bit          leap;
    bit          found;
    day_num = secs / DaySecs + 1;
    rem     = secs % DaySecs;
    dt.hour   = 5'(rem / HourSecs);
    rem       = rem % HourSecs;
    dt.minute = 6'(rem / MinuteSecs);
    dt.second = 6'(rem % MinuteSecs);
    yr   = FIRST_YEAR;
    ylen = 365;
    while (day_num > ylen) begin
      day_num -= ylen;
      yr++;
      ylen = is_leap_year(yr) ? 366 : 365;
    end
    leap  = is_leap_year(yr);
    mon   = DECEMBER;
    found = 1'b0;
    for (int unsigned m = JANUARY; m <= DECEMBER; m++) begin
      if (!found) begin
        if (day_num <= days_in_month(m, leap)) begin
          mon   = m;
          found = 1'b1;
        end else begin
          day_num -= days_in_month(m, leap);
        end
      end
    end
    dt.year  = 12'(yr);
    dt.month = 4'(mon);
    dt.day   = 5'(day_num);
    return dt;
  endfunction

  // Pick uniform seconds, or seconds near a midnight, a month start or the top of range
  function automatic logic [31:0] random_epoch();
    longint      secs;
    longint      day_cnt;
    int unsigned yr;
    int unsigned mon;
    case ($urandom_range(0, 3))
      0: secs = $urandom();
      1: secs = longint'($urandom_range(0, LastDay)) * DaySecs + $urandom_range(0, 4) - 2;
      2: secs = 64'hFFFF_FFFF - $urandom_range(0, 200000);
      default: begin
        yr      = $urandom_range(1970, 2106);
        mon     = $urandom_range(1, 12);
        day_cnt = 0;
        for (int unsigned y = 1970; y < yr; y++) begin
          day_cnt += is_leap_year(y) ? 366 : 365;
        end
        for (int unsigned m = 1; m < mon; m++) begin
          day_cnt += days_in_month(m, is_leap_year(yr));
        end
        secs = day_cnt * DaySecs + $urandom_range(0, 4) - 2;
      end
    endcase
    if (secs < 0) begin
      secs = 0;
    end else if (secs > 64'hFFFF_FFFF) begin
      secs = 64'hFFFF_FFFF;
    end
    return secs[31:0];
  endfunction

  // Offer one request after a random gap; leave valid high so back-to-back requests don't glitch
  task automatic send_request(input logic [31:0] secs);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_epoch_seconds <= secs;
    do @(posedge clk); while (in_stall);
    pending_datetimes.push_back(predict_datetime(secs));
  endtask

  // Drop valid and wait for every pending result, then let the block settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_datetimes.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic run_random(input int unsigned count, input int unsigned send_pct,
                            input int unsigned recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    repeat (count) send_request(random_epoch());
    wait_drained();
  endtask

  task automatic test_corner_values();
    logic [31:0] corners[$];
    corners = '{32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
                32'd68169599, 32'd68169600, 32'd94694399, 32'd94694400,
                32'd946684799, 32'd951782400, 32'd951868800,
                32'd4107542399, 32'd4107542400,
                32'h7FFF_FFFF, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA,
                32'hFFFF_FFFE, 32'hFFFF_FFFF};
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    foreach (corners[i]) send_request(corners[i]);
    wait_drained();
  endtask

  task automatic test_streaming();
    run_random(330, 0, 0);
  endtask

  task automatic test_sender_gaps();
    run_random(330, 78, 0);
  endtask

  task automatic test_receiver_stalls();
    run_random(330, 0, 78);
  endtask

  task automatic test_mixed_idling();
    run_random(420, 22, 22);
  endtask

  // Hold the result side off while requests keep coming, so the input backs up
  task automatic test_backpressure_fill();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    long_hold_req  = LongHold;
    repeat (12) send_request(random_epoch());
    wait_drained();
  endtask

  // Stall the result channel at random, or for a long stretch on request
  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (long_hold_req != 0) begin
        hold_left     = long_hold_req;
        long_hold_req = 0;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  // Compare each accepted result with the oldest prediction
  initial begin : result_checker
    datetime_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (pending_datetimes.size() == 0) begin
          $display("%0t: unexpected result %0d-%0d-%0d %0d:%0d:%0d", $time, out_year_out,
                   out_month_out, out_day_out, out_hour_out, out_minute_out, out_second_out);
          error_count++;
        end else begin
          want = pending_datetimes.pop_front();
          if (out_year_out !== want.year) begin
            $display("%0t: year expected %0d got %0d", $time, want.year, out_year_out);
            error_count++;
          end
          if (out_month_out !== want.month) begin
            $display("%0t: month expected %0d got %0d", $time, want.month, out_month_out);
            error_count++;
          end
          if (out_day_out !== want.day) begin
            $display("%0t: day expected %0d got %0d", $time, want.day, out_day_out);
            error_count++;
          end
          if (out_hour_out !== want.hour) begin
            $display("%0t: hour expected %0d got %0d", $time, want.hour, out_hour_out);
            error_count++;
          end
          if (out_minute_out !== want.minute) begin
            $display("%0t: minute expected %0d got %0d", $time, want.minute, out_minute_out);
            error_count++;
          end
          if (out_second_out !== want.second) begin
            $display("%0t: second expected %0d got %0d", $time, want.second, out_second_out);
            error_count++;
          end
        end
      end
    end
  end

  // End the run if no request or result moves for too long
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("%0t: timeout, %0d results outstanding", $time, pending_datetimes.size());
        $display("FAIL epoch_seconds_to_datetime_core");
        $finish;
      end
    end
  end

  initial begin : main_sequence
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_corner_values();
    test_streaming();
    test_sender_gaps();
    test_receiver_stalls();
    test_mixed_idling();
    test_backpressure_fill();
    if (error_count == 0 && pending_datetimes.size() == 0) begin
      $display("PASS epoch_seconds_to_datetime_core");
    end else begin
      $display("FAIL epoch_seconds_to_datetime_core");
    end
    $finish;
  end

endmodule
